// File: design/mlt_pkg.sv
package mlt_pkg;

  // Width of one code point.
  localparam int unsigned CpW = 21;

  // Characters with a special meaning at line start or anywhere.
  localparam logic [CpW-1:0] ChHash      = CpW'(8'h23);
  localparam logic [CpW-1:0] ChBackquote = CpW'(8'h60);
  localparam logic [CpW-1:0] ChNewline   = CpW'(8'h0A);

  // Backquotes that complete a backquote token.
  localparam logic [1:0] BackquotesNeeded = 2'd3;

  typedef enum logic [1:0] {
    EV_APPEND = 2'd0,
    EV_DONE   = 2'd1,
    EV_ERROR  = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    KIND_EOF       = 3'd0,
    KIND_NEWLINE   = 3'd1,
    KIND_HEADER    = 3'd2,
    KIND_BACKQUOTE = 3'd3,
    KIND_TEXT      = 3'd4
  } kind_t;

  // One result beat.
  typedef struct packed {
    kind_t          kind;
    event_t         ev;
    logic [CpW-1:0] ch;
    logic           last;
  } result_t;

  // All results of one character, slot 0 first, and how many are valid (1 to 3).
  typedef struct packed {
    result_t [2:0] res;
    logic [1:0]    count;
  } step_t;

endpackage

// File: design/mlt_core.sv
module mlt_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [mlt_pkg::CpW-1:0] cp,
  input  logic                    eoi,
  output mlt_pkg::step_t          results
);
  import mlt_pkg::*;

  typedef enum logic [1:0] {
    MODE_START     = 2'd0,
    MODE_HEADER    = 2'd1,
    MODE_BACKQUOTE = 2'd2,
    MODE_TEXT      = 2'd3
  } mode_t;

  mode_t      mode, mode_next;
  logic [1:0] bq_count, bq_count_next;
  logic       at_line_start, at_line_start_next;

  result_t    r [3];
  logic [1:0] n;
  logic       is_hash, is_bq, is_nl;
  logic [1:0] bq_inc;

  // Line-start rules: the result they give and the mode they leave.
  function automatic result_t start_result(input logic [CpW-1:0] c, input logic sol);
    result_t s;
    s.last = 1'b0;
    if (c == ChHash && sol) begin
      s.ev = EV_APPEND; s.kind = KIND_HEADER; s.ch = c;
    end else if (c == ChBackquote && sol) begin
      s.ev = EV_APPEND; s.kind = KIND_BACKQUOTE; s.ch = c;
    end else if (c == ChNewline) begin
      s.ev = EV_DONE; s.kind = KIND_NEWLINE; s.ch = '0;
    end else begin
      s.ev = EV_APPEND; s.kind = KIND_TEXT; s.ch = c;
    end
    return s;
  endfunction

  function automatic mode_t start_mode(input logic [CpW-1:0] c, input logic sol);
    mode_t m;
    if (c == ChHash && sol) begin
      m = MODE_HEADER;
    end else if (c == ChBackquote && sol) begin
      m = MODE_BACKQUOTE;
    end else if (c == ChNewline) begin
      m = MODE_START;
    end else begin
      m = MODE_TEXT;
    end
    return m;
  endfunction

  assign is_hash = (cp == ChHash);
  assign is_bq   = (cp == ChBackquote);
  assign is_nl   = (cp == ChNewline);
  assign bq_inc  = bq_count + 2'd1;

  // Results and next state for the character held in the input register.
  always_comb begin
    r[0] = '0;
    r[1] = '0;
    r[2] = '0;
    n = 2'd1;
    mode_next = mode;
    bq_count_next = bq_count;
    at_line_start_next = is_nl;
    if (eoi) begin
      at_line_start_next = 1'b1;
      mode_next = MODE_START;
      bq_count_next = 2'd0;
      r[0].ev = EV_DONE;
      r[1].ev = EV_DONE;
      r[1].kind = KIND_EOF;
      unique case (mode)
        MODE_HEADER:    begin r[0].kind = KIND_HEADER;    n = 2'd2; end
        MODE_BACKQUOTE: begin r[0].kind = KIND_BACKQUOTE; n = 2'd2; end
        MODE_TEXT:      begin r[0].kind = KIND_TEXT;      n = 2'd2; end
        default:        begin r[0].kind = KIND_EOF;       n = 2'd1; end
      endcase
    end else begin
      unique case (mode)
        MODE_HEADER: begin
          if (is_hash) begin
            r[0].ev = EV_APPEND; r[0].kind = KIND_HEADER; r[0].ch = cp;
          end else begin
            r[0].ev = EV_DONE; r[0].kind = KIND_HEADER;
            r[1] = start_result(cp, at_line_start);
            mode_next = start_mode(cp, at_line_start);
            if (cp == ChBackquote && at_line_start) begin
              bq_count_next = 2'd1;
            end
            n = 2'd2;
          end
        end
        MODE_BACKQUOTE: begin
          if (is_bq) begin
            r[0].ev = EV_APPEND; r[0].kind = KIND_BACKQUOTE; r[0].ch = cp;
            bq_count_next = bq_inc;
            // A count that wraps to zero also completes the token.
            if (bq_inc == BackquotesNeeded || bq_inc == 2'd0) begin
              r[1].ev = EV_DONE; r[1].kind = KIND_BACKQUOTE;
              mode_next = MODE_START;
              bq_count_next = 2'd0;
              n = 2'd2;
            end
          end else begin
            // Short run: flag it, then the character carries on as text.
            r[0].ev = EV_ERROR; r[0].kind = KIND_BACKQUOTE;
            bq_count_next = 2'd0;
            if (is_nl) begin
              r[1].ev = EV_DONE; r[1].kind = KIND_TEXT;
              r[2].ev = EV_DONE; r[2].kind = KIND_NEWLINE;
              mode_next = MODE_START;
              n = 2'd3;
            end else begin
              r[1].ev = EV_APPEND; r[1].kind = KIND_TEXT; r[1].ch = cp;
              mode_next = MODE_TEXT;
              n = 2'd2;
            end
          end
        end
        MODE_TEXT: begin
          if (is_nl) begin
            r[0].ev = EV_DONE; r[0].kind = KIND_TEXT;
            r[1].ev = EV_DONE; r[1].kind = KIND_NEWLINE;
            mode_next = MODE_START;
            n = 2'd2;
          end else begin
            r[0].ev = EV_APPEND; r[0].kind = KIND_TEXT; r[0].ch = cp;
          end
        end
        default: begin
          r[0] = start_result(cp, at_line_start);
          mode_next = start_mode(cp, at_line_start);
          if (cp == ChBackquote && at_line_start) begin
            bq_count_next = 2'd1;
          end
        end
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      r[i].last = (2'(i) == n - 2'd1);
    end
  end

  assign results.res[0] = r[0];
  assign results.res[1] = r[1];
  assign results.res[2] = r[2];
  assign results.count  = n;

  // Lexer state advances once per character handed to the result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      bq_count <= 2'd0;
      at_line_start <= 1'b1;
    end else if (step) begin
      mode <= mode_next;
      bq_count <= bq_count_next;
      at_line_start <= at_line_start_next;
    end
  end

endmodule

// File: design/mlt_outbuf.sv
module mlt_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  mlt_pkg::step_t   results,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output mlt_pkg::result_t out_res
);
  import mlt_pkg::*;

  result_t    slot [3];
  logic [1:0] cnt;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign out_res   = slot[0];
  assign pop       = out_valid && out_ready;

  // A new set of results loads once the buffer is empty or its last beat leaves now.
  assign take = in_valid && ((cnt == 2'd0) || (cnt == 2'd1 && out_ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (take) begin
      cnt <= results.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Slot 0 always faces the output; later beats shift down as each one leaves.
  always_ff @(posedge clk) begin
    if (take) begin
      slot[0] <= results.res[0];
      slot[1] <= results.res[1];
      slot[2] <= results.res[2];
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

// File: design/markup_line_tokenizer.sv
// Channel  Direction  Payload
// s_*      in         tdata: code_point [20:0], zeros [23:21]; tlast: end of input
// m_*      out        tdata: char_out [20:0], zeros [23:21];
//                     tuser: event [1:0], token kind [4:2]; tlast: last beat of a character
//
// A character is registered on entry, its results are worked out from the input register
// and loaded into a three-beat result buffer; the first result appears once they are loaded.
// One character per cycle is taken while each causes one result and m_tready stays high; a
// character with two or three results holds the result buffer for that many output beats.
// Reset clears the lexer to start mode at line start and empties both stages.
// A stall on m_tready fills the buffer and then the input register before s_tready drops.
module markup_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // code_point [20:0], zero pad [23:21]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // char_out [20:0], zero pad [23:21]
  output logic [4:0]  m_tuser,   // event_res [1:0], token_kind [4:2]
  output logic        m_tlast
);
  import mlt_pkg::*;

  logic           in_valid;
  logic [CpW-1:0] in_cp;
  logic           in_eoi;
  logic           take;
  step_t          results;
  result_t        out_res;

  assign s_tready = !in_valid || take;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cp  <= s_tdata[CpW-1:0];
      in_eoi <= s_tlast;
    end
  end

  mlt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (take),
    .cp      (in_cp),
    .eoi     (in_eoi),
    .results (results)
  );

  mlt_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .results   (results),
    .take      (take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {3'b000, out_res.ch};
  assign m_tuser = {out_res.kind, out_res.ev};
  assign m_tlast = out_res.last;

endmodule

// File: verif/markup_line_tokenizer_test.sv
`timescale 1ns / 100ps

module markup_line_tokenizer_test;
  import mlt_pkg::*;

  // Cycles without any beat on either side before the run is abandoned.
  localparam int WatchdogLimit = 2000;
  localparam int DirectedChars = 24;
  localparam int RandomChars = 300;
  localparam logic [CpW-1:0] CpMax = CpW'(21'h1FFFFF);

  // Line tokenizer predictor and result scoreboard.
  class tok_scoreboard;
    typedef enum logic [1:0] {
      LEX_START     = 2'd0,
      LEX_HEADER    = 2'd1,
      LEX_BACKQUOTE = 2'd2,
      LEX_TEXT      = 2'd3
    } lex_mode_t;

    lex_mode_t  mode;
    logic [1:0] bq_count;
    logic       line_start;
    result_t    pending_beats[$];
    int         mismatches;

    function new();
      clear_lexer();
      mismatches = 0;
    endfunction

    function void clear_lexer();
      mode = LEX_START;
      bq_count = 2'd0;
      line_start = 1'b1;
    endfunction

    function void add_beat(event_t ev, kind_t kind, logic [CpW-1:0] ch);
      result_t r;
      r.kind = kind;
      r.ev = ev;
      r.ch = ch;
      r.last = 1'b0;
      pending_beats.push_back(r);
    endfunction

    // Rules for a character that opens a new token.
    function void open_token(logic [CpW-1:0] c);
      if (c == ChHash && line_start) begin
        mode = LEX_HEADER;
        add_beat(EV_APPEND, KIND_HEADER, c);
      end else if (c == ChBackquote && line_start) begin
        mode = LEX_BACKQUOTE;
        bq_count = 2'd1;
        add_beat(EV_APPEND, KIND_BACKQUOTE, c);
      end else if (c == ChNewline) begin
        mode = LEX_START;
        add_beat(EV_DONE, KIND_NEWLINE, '0);
      end else begin
        mode = LEX_TEXT;
        add_beat(EV_APPEND, KIND_TEXT, c);
      end
    endfunction

    // A newline closes the text token and is then taken as a newline token.
    function void extend_text(logic [CpW-1:0] c);
      if (c == ChNewline) begin
        add_beat(EV_DONE, KIND_TEXT, '0);
        mode = LEX_START;
        open_token(c);
      end else begin
        add_beat(EV_APPEND, KIND_TEXT, c);
      end
    endfunction

    // Works out every result beat of one accepted character.
    function void predict_char(logic [CpW-1:0] c, logic eoi);
      if (eoi) begin
        case (mode)
          LEX_HEADER:    add_beat(EV_DONE, KIND_HEADER, '0);
          LEX_BACKQUOTE: add_beat(EV_DONE, KIND_BACKQUOTE, '0);
          LEX_TEXT:      add_beat(EV_DONE, KIND_TEXT, '0);
          default: ;
        endcase
        add_beat(EV_DONE, KIND_EOF, '0);
        clear_lexer();
      end else begin
        case (mode)
          LEX_HEADER: begin
            if (c == ChHash) begin
              add_beat(EV_APPEND, KIND_HEADER, c);
            end else begin
              add_beat(EV_DONE, KIND_HEADER, '0);
              mode = LEX_START;
              open_token(c);
            end
          end
          LEX_BACKQUOTE: begin
            if (c == ChBackquote) begin
              add_beat(EV_APPEND, KIND_BACKQUOTE, c);
              bq_count = bq_count + 2'd1;
              // A wrapped count also completes the run.
              if (bq_count == BackquotesNeeded || bq_count == 2'd0) begin
                add_beat(EV_DONE, KIND_BACKQUOTE, '0);
                mode = LEX_START;
                bq_count = 2'd0;
              end
            end else begin
              // Short run: report it and carry on as text.
              add_beat(EV_ERROR, KIND_BACKQUOTE, '0);
              bq_count = 2'd0;
              mode = LEX_TEXT;
              extend_text(c);
            end
          end
          LEX_TEXT: extend_text(c);
          default:  open_token(c);
        endcase
        line_start = (c == ChNewline);
      end
      pending_beats[pending_beats.size() - 1].last = 1'b1;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // Compares one result beat with the oldest outstanding prediction.
    function void check_beat(logic [23:0] tdata, logic [4:0] tuser, logic tlast);
      result_t want;
      if (pending_beats.size() == 0) begin
        flag($sformatf("unexpected result beat: tdata=%h tuser=%h tlast=%b",
                       tdata, tuser, tlast));
        return;
      end
      want = pending_beats.pop_front();
      if (tuser[1:0] !== want.ev || tuser[4:2] !== want.kind ||
          tdata !== 24'(want.ch) || tlast !== want.last)
        flag($sformatf({"result mismatch: expected ev=%0d kind=%0d ch=%h last=%b, ",
                        "got ev=%0d kind=%0d tdata=%h last=%b"},
                       want.ev, want.kind, want.ch, want.last,
                       tuser[1:0], tuser[4:2], tdata, tlast));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  tok_scoreboard sb = new();
  int  chars_taken = 0;
  int  chars_sent = 0;
  int  stall_cycles = 0;
  bit  steady = 1'b0;

  markup_line_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Sample both channels at the rising edge and keep the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
      if (s_tvalid && s_tready) begin
        sb.predict_char(s_tdata[CpW-1:0], s_tlast);
        chars_taken++;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles == WatchdogLimit) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off to fill the pipeline.
  initial begin : receiver
    int hold_left = 0;
    bit held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && chars_taken >= 60) begin
        held = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (steady) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 31);
      end
    end
  end

  // Offers one character beat, with random gaps ahead of it, until it is taken.
  task automatic send_char(input logic [CpW-1:0] cp, input logic eoi);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= 24'(cp);
    s_tlast <= eoi;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  function automatic logic [CpW-1:0] pick_content();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return CpW'($urandom_range(8'h20, 8'h7E));
    else if (sel < 80) return CpW'($urandom());
    else if (sel < 90) return ChHash;
    else return ChBackquote;
  endfunction

  // One line of markup with random content, ended by a newline or end of input.
  task automatic send_line();
    int sel;
    int n;
    sel = $urandom_range(99);
    if (sel < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) send_char(ChHash, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) send_char(pick_content(), 1'b0);
    end else if (sel < 30) begin
      repeat (3) send_char(ChBackquote, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) send_char(pick_content(), 1'b0);
    end else if (sel < 40) begin
      n = $urandom_range(1, 2);
      repeat (n) send_char(ChBackquote, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) send_char(pick_content(), 1'b0);
    end else if (sel < 50) begin
      // Noise, end-of-input marks scattered among it.
      n = $urandom_range(1, 8);
      repeat (n) send_char(CpW'($urandom()), $urandom_range(7) == 0);
    end else if (sel >= 55) begin
      n = $urandom_range(1, 10);
      repeat (n) send_char(pick_content(), 1'b0);
    end
    if ($urandom_range(99) < 8) send_char(CpW'($urandom()), 1'b1);
    else send_char(ChNewline, 1'b0);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: header, fences, short runs, end of input in each mode, extremes.
    send_char(ChHash, 1'b0);
    send_char(ChHash, 1'b0);
    send_char(CpW'(8'h78), 1'b0);
    send_char(ChNewline, 1'b0);
    repeat (3) send_char(ChBackquote, 1'b0);
    send_char(ChNewline, 1'b0);
    send_char(ChBackquote, 1'b0);
    send_char(CpW'(8'h61), 1'b0);
    send_char(ChNewline, 1'b0);
    repeat (2) send_char(ChBackquote, 1'b0);
    send_char(ChNewline, 1'b0);
    send_char(ChHash, 1'b0);
    send_char(CpMax, 1'b1);
    send_char(ChBackquote, 1'b0);
    send_char('0, 1'b1);
    send_char(CpMax, 1'b0);
    send_char(ChHash, 1'b0);
    send_char('0, 1'b0);
    send_char(CpW'(21'h00D800), 1'b0);
    send_char(CpW'($urandom()), 1'b1);
    send_char(CpW'($urandom()), 1'b1);

    // Random lines, with a stretch where neither side idles.
    while (chars_sent < DirectedChars + RandomChars) begin
      steady = (chars_sent >= 120 && chars_sent < 200);
      send_line();
    end
    steady = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
